// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } ctrl_state_type;

   typedef enum logic {
      ACTION_GET = 1'b0,
      ACTION_SET = 1'b1
   } action_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0
   } reg_index_type;

   // search token that walks the cell row
   typedef struct packed {
      logic               active;
      logic               found;
      logic               free_found;
      logic               lru_found;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] found_value;
   } probe_type;

   // update broadcast to all cells
   typedef struct packed {
      logic               en;
      logic               insert;
      logic               write_kv;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

// ===== rtl/core/lkvc_cell.sv =====
module lkvc_cell #(
   parameter int SLOT_W = 4,
   parameter int INDEX  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lkvc_pkg::probe_type up_probe,
   input  logic [SLOT_W-1:0]   up_found_slot,
   input  logic [SLOT_W-1:0]   up_found_rank,
   input  logic [SLOT_W-1:0]   up_free_slot,
   input  logic [SLOT_W-1:0]   up_lru_slot,
   input  logic [SLOT_W-1:0]   up_lru_rank,
   output lkvc_pkg::probe_type dn_probe,
   output logic [SLOT_W-1:0]   dn_found_slot,
   output logic [SLOT_W-1:0]   dn_found_rank,
   output logic [SLOT_W-1:0]   dn_free_slot,
   output logic [SLOT_W-1:0]   dn_lru_slot,
   output logic [SLOT_W-1:0]   dn_lru_rank,
   input  lkvc_pkg::cmd_type   cmd,
   input  logic [SLOT_W-1:0]   cmd_slot,
   input  logic [SLOT_W-1:0]   cmd_rank
);
   import lkvc_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic               valid_ff, valid_in;
   logic [SLOT_W-1:0]  rank_ff, rank_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   probe_type          probe_ff, probe_in;
   logic [SLOT_W-1:0]  found_slot_ff, found_slot_in;
   logic [SLOT_W-1:0]  found_rank_ff, found_rank_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]  lru_slot_ff, lru_slot_in;
   logic [SLOT_W-1:0]  lru_rank_ff, lru_rank_in;

   logic               match;
   logic               target;

   // probe stage
   always_comb begin
      probe_in      = up_probe;
      found_slot_in = up_found_slot;
      found_rank_in = up_found_rank;
      free_slot_in  = up_free_slot;
      lru_slot_in   = up_lru_slot;
      lru_rank_in   = up_lru_rank;
      match = up_probe.active && valid_ff && !up_probe.found && (key_ff == up_probe.key);
      if (match) begin
         probe_in.found       = 1'b1;
         probe_in.found_value = value_ff;
         found_slot_in        = MY_SLOT;
         found_rank_in        = rank_ff;
      end
      if (up_probe.active && !valid_ff && !up_probe.free_found) begin
         probe_in.free_found = 1'b1;
         free_slot_in        = MY_SLOT;
      end
      if (up_probe.active && valid_ff && (!up_probe.lru_found || rank_ff > up_lru_rank)) begin
         probe_in.lru_found = 1'b1;
         lru_slot_in        = MY_SLOT;
         lru_rank_in        = rank_ff;
      end
   end

   // entry update
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      target   = cmd.en && (cmd_slot == MY_SLOT);
      if (cmd.en) begin
         if (cmd.insert) begin
            if (valid_ff) begin
               rank_in = rank_ff + SLOT_W'(1);
            end
         end else if (valid_ff && !target && (rank_ff < cmd_rank)) begin
            rank_in = rank_ff + SLOT_W'(1);
         end
      end
      if (target) begin
         valid_in = 1'b1;
         rank_in  = '0;
         if (cmd.write_kv) begin
            key_in   = cmd.key;
            value_in = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      value_ff      <= value_in;
      found_slot_ff <= found_slot_in;
      found_rank_ff <= found_rank_in;
      free_slot_ff  <= free_slot_in;
      lru_slot_ff   <= lru_slot_in;
      lru_rank_ff   <= lru_rank_in;
   end

   assign dn_probe      = probe_ff;
   assign dn_found_slot = found_slot_ff;
   assign dn_found_rank = found_rank_ff;
   assign dn_free_slot  = free_slot_ff;
   assign dn_lru_slot   = lru_slot_ff;
   assign dn_lru_rank   = lru_rank_ff;

endmodule

// ===== rtl/core/lkvc_ctrl.sv =====
module lkvc_ctrl #(
   parameter int MAX_ENTRIES = 16,
   parameter int SLOT_W      = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic [0:0]                 rsp_tuser,
   input  logic [lkvc_pkg::CAP_W-1:0] capacity,
   output lkvc_pkg::probe_type        launch_probe,
   input  lkvc_pkg::probe_type        up_probe,
   input  logic [SLOT_W-1:0]          up_found_slot,
   input  logic [SLOT_W-1:0]          up_found_rank,
   input  logic [SLOT_W-1:0]          up_free_slot,
   input  logic [SLOT_W-1:0]          up_lru_slot,
   input  logic [SLOT_W-1:0]          up_lru_rank,
   output lkvc_pkg::cmd_type          cmd,
   output logic [SLOT_W-1:0]          cmd_slot,
   output logic [SLOT_W-1:0]          cmd_rank
);
   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   ctrl_state_type     state_ff, state_in;
   probe_type          probe_ff, probe_in;
   action_type         action_ff, action_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               res_found_ff, res_found_in;
   logic               res_free_found_ff, res_free_found_in;
   logic               res_lru_found_ff, res_lru_found_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [SLOT_W-1:0]  res_found_slot_ff, res_found_slot_in;
   logic [SLOT_W-1:0]  res_found_rank_ff, res_found_rank_in;
   logic [SLOT_W-1:0]  res_free_slot_ff, res_free_slot_in;
   logic [SLOT_W-1:0]  res_lru_slot_ff, res_lru_slot_in;
   logic [SLOT_W-1:0]  res_lru_rank_ff, res_lru_rank_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]      cap_eff;
   logic               rsp_free;
   logic               has_room;

   // capacity clamped to 1..MAX_ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CW'(1);
      end else if (CW'(capacity) > CW'(MAX_ENTRIES)) begin
         cap_eff = CW'(MAX_ENTRIES);
      end else begin
         cap_eff = CW'(capacity);
      end
   end

   assign has_room = CW'(count_ff) < cap_eff;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in          = state_ff;
      probe_in          = probe_ff;
      probe_in.active   = 1'b0;
      action_in         = action_ff;
      key_in            = key_ff;
      value_in          = value_ff;
      count_in          = count_ff;
      res_found_in      = res_found_ff;
      res_free_found_in = res_free_found_ff;
      res_lru_found_in  = res_lru_found_ff;
      res_value_in      = res_value_ff;
      res_found_slot_in = res_found_slot_ff;
      res_found_rank_in = res_found_rank_ff;
      res_free_slot_in  = res_free_slot_ff;
      res_lru_slot_in   = res_lru_slot_ff;
      res_lru_rank_in   = res_lru_rank_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_hit_in        = rsp_hit_ff;
      rsp_data_in       = rsp_data_ff;
      req_tready        = 1'b0;
      cmd               = '0;
      cmd.key           = key_ff;
      cmd.value         = value_ff;
      cmd_slot          = '0;
      cmd_rank          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in        = ST_SCAN;
               action_in       = action_type'(req_tuser[0]);
               key_in          = req_tdata[31:0];
               value_in        = req_tdata[63:32];
               probe_in        = '0;
               probe_in.active = 1'b1;
               probe_in.key    = req_tdata[31:0];
            end
         end
         ST_SCAN: begin
            if (up_probe.active) begin
               state_in          = ST_APPLY;
               res_found_in      = up_probe.found;
               res_free_found_in = up_probe.free_found;
               res_lru_found_in  = up_probe.lru_found;
               res_value_in      = up_probe.found_value;
               res_found_slot_in = up_found_slot;
               res_found_rank_in = up_found_rank;
               res_free_slot_in  = up_free_slot;
               res_lru_slot_in   = up_lru_slot;
               res_lru_rank_in   = up_lru_rank;
            end
         end
         ST_APPLY: begin
            if (action_ff == ACTION_SET || rsp_free) begin
               state_in = ST_IDLE;
               if (action_ff == ACTION_GET) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = res_found_ff;
                  rsp_data_in  = res_found_ff ? res_value_ff : '1;
                  if (res_found_ff) begin
                     cmd.en   = 1'b1;
                     cmd_slot = res_found_slot_ff;
                     cmd_rank = res_found_rank_ff;
                  end
               end else if (res_found_ff) begin
                  cmd.en       = 1'b1;
                  cmd.write_kv = 1'b1;
                  cmd_slot     = res_found_slot_ff;
                  cmd_rank     = res_found_rank_ff;
               end else if (has_room && res_free_found_ff) begin
                  cmd.en       = 1'b1;
                  cmd.insert   = 1'b1;
                  cmd.write_kv = 1'b1;
                  cmd_slot     = res_free_slot_ff;
                  count_in     = count_ff + CNT_W'(1);
               end else if (res_lru_found_ff) begin
                  // evict least recently used entry
                  cmd.en       = 1'b1;
                  cmd.write_kv = 1'b1;
                  cmd_slot     = res_lru_slot_ff;
                  cmd_rank     = res_lru_rank_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         probe_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff         <= action_in;
      key_ff            <= key_in;
      value_ff          <= value_in;
      res_found_ff      <= res_found_in;
      res_free_found_ff <= res_free_found_in;
      res_lru_found_ff  <= res_lru_found_in;
      res_value_ff      <= res_value_in;
      res_found_slot_ff <= res_found_slot_in;
      res_found_rank_ff <= res_found_rank_in;
      res_free_slot_ff  <= res_free_slot_in;
      res_lru_slot_ff   <= res_lru_slot_in;
      res_lru_rank_ff   <= res_lru_rank_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_data_ff       <= rsp_data_in;
   end

   assign launch_probe = probe_ff;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser    = rsp_hit_ff;

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// items are handled one at a time: a request is accepted only in the idle state, so a new item
// is not taken before the last one is through; the search token steps through the row of
// cells one cell per cycle, a capture step records the result, an apply step applies the update to
// all cells and the controller then accepts the next item; a get waits longer while rsp is stalled
// reset: synchronous, clears valid bits, recency ranks, entry count and handshakes at once;
// capacity returns to 16; no clearing pass
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lookup_key, store_value
   input  logic [0:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value
   output logic [0:0]  rsp_tuser,   // hit
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lkvc_pkg::*;

   localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   reg_index_type     csr_index;

   probe_type         chain_probe      [MAX_ENTRIES+1];
   logic [SLOT_W-1:0] chain_found_slot [MAX_ENTRIES+1];
   logic [SLOT_W-1:0] chain_found_rank [MAX_ENTRIES+1];
   logic [SLOT_W-1:0] chain_free_slot  [MAX_ENTRIES+1];
   logic [SLOT_W-1:0] chain_lru_slot   [MAX_ENTRIES+1];
   logic [SLOT_W-1:0] chain_lru_rank   [MAX_ENTRIES+1];

   cmd_type           cmd;
   logic [SLOT_W-1:0] cmd_slot;
   logic [SLOT_W-1:0] cmd_rank;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_index == REG_CAPACITY) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
      case (csr_index)
         REG_CAPACITY: csr_prdata = {{(32-CAP_W){1'b0}}, capacity_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign chain_found_slot[0] = '0;
   assign chain_found_rank[0] = '0;
   assign chain_free_slot[0]  = '0;
   assign chain_lru_slot[0]   = '0;
   assign chain_lru_rank[0]   = '0;

   lkvc_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SLOT_W      (SLOT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .capacity      (capacity_ff),
      .launch_probe  (chain_probe[0]),
      .up_probe      (chain_probe[MAX_ENTRIES]),
      .up_found_slot (chain_found_slot[MAX_ENTRIES]),
      .up_found_rank (chain_found_rank[MAX_ENTRIES]),
      .up_free_slot  (chain_free_slot[MAX_ENTRIES]),
      .up_lru_slot   (chain_lru_slot[MAX_ENTRIES]),
      .up_lru_rank   (chain_lru_rank[MAX_ENTRIES]),
      .cmd           (cmd),
      .cmd_slot      (cmd_slot),
      .cmd_rank      (cmd_rank)
   );

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .SLOT_W (SLOT_W),
         .INDEX  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .up_probe      (chain_probe[i]),
         .up_found_slot (chain_found_slot[i]),
         .up_found_rank (chain_found_rank[i]),
         .up_free_slot  (chain_free_slot[i]),
         .up_lru_slot   (chain_lru_slot[i]),
         .up_lru_rank   (chain_lru_rank[i]),
         .dn_probe      (chain_probe[i+1]),
         .dn_found_slot (chain_found_slot[i+1]),
         .dn_found_rank (chain_found_rank[i+1]),
         .dn_free_slot  (chain_free_slot[i+1]),
         .dn_lru_slot   (chain_lru_slot[i+1]),
         .dn_lru_rank   (chain_lru_rank[i+1]),
         .cmd           (cmd),
         .cmd_slot      (cmd_slot),
         .cmd_rank      (cmd_rank)
      );
   end

endmodule
